/* src/rpu_pkg.sv */
package rpu_pkg;

	// Configuration register indexes.
	localparam logic [1:0] REG_DECAY  = 2'd0;
	localparam logic [1:0] REG_WRATE  = 2'd1;
	localparam logic [1:0] REG_BRATE  = 2'd2;
	localparam logic [1:0] REG_EPS    = 2'd3;

	// Register reset values.
	localparam logic [15:0] DECAY_RST = 16'd58982;
	localparam logic [23:0] WRATE_RST = 24'd167772;
	localparam logic [23:0] BRATE_RST = 24'd167772;
	localparam logic [15:0] EPS_RST   = 16'd168;

	// 1.0 in the Q0.16 decay format.
	localparam logic [16:0] DECAY_ONE = 17'h10000;

	// Fields that ride along with an element from start to end.
	typedef struct packed {
		logic [31:0] w;
		logic        gneg;
		logic        last;
	} side_t;

	// Carried through the square root stages.
	typedef struct packed {
		side_t       base;
		logic [31:0] ms;
		logic [55:0] n;
		logic        sat;
	} rt_side_t;

	// Carried through the divider stages.
	typedef struct packed {
		side_t       base;
		logic [31:0] ms;
		logic        sat;
	} dv_side_t;

	// One finished result.
	typedef struct packed {
		logic [31:0] param;
		logic [31:0] ms;
		logic        sat;
		logic        last;
	} res_t;

endpackage

/* src/rpu_ms.sv */
module rpu_ms #(
	parameter int FRACTION_BITS = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [31:0]         gmag,
	input  logic [31:0]         ms_in,
	input  logic [23:0]         rate,
	input  logic [15:0]         decay,
	input  rpu_pkg::side_t      side_in,
	output logic                out_valid,
	output logic [31:0]         ms_new,
	output logic                sat,
	output logic [55:0]         n,
	output rpu_pkg::side_t      side_out
);

	// Stage 1: gradient square and rate product.
	logic [63:0]    sq_full_s1;
	logic [55:0]    n_s1;
	logic [31:0]    ms_s1;
	rpu_pkg::side_t side_s1;
	logic           vld_s1;

	// Stage 2: decay products.
	logic [47:0]    p1_s2;
	logic [64:0]    p2_s2;
	logic           big_s2;
	logic [55:0]    n_s2;
	rpu_pkg::side_t side_s2;
	logic           vld_s2;

	// Stage 3: sum.
	logic [65:0]    acc_s3;
	logic           big_s3;
	logic [55:0]    n_s3;
	rpu_pkg::side_t side_s3;
	logic           vld_s3;

	// Stage 4: scaled and clamped mean square.
	logic [31:0]    ms_s4;
	logic           sat_s4;
	logic [55:0]    n_s4;
	rpu_pkg::side_t side_s4;
	logic           vld_s4;

	logic [63:0] sq_sh;
	logic [16:0] decay_c;

	assign sq_sh   = sq_full_s1 >> FRACTION_BITS;
	assign decay_c = rpu_pkg::DECAY_ONE - {1'b0, decay};

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// Data path.
	always_ff @(posedge clk) begin
		if (en) begin
			sq_full_s1 <= 64'(gmag) * 64'(gmag);
			n_s1       <= 56'(rate) * 56'(gmag);
			ms_s1      <= ms_in;
			side_s1    <= side_in;

			p1_s2      <= 48'(decay) * 48'(ms_s1);
			p2_s2      <= 65'(decay_c) * 65'(sq_sh[47:0]);
			big_s2     <= |sq_sh[63:48];
			n_s2       <= n_s1;
			side_s2    <= side_s1;

			acc_s3     <= 66'(p1_s2) + 66'(p2_s2);
			big_s3     <= big_s2;
			n_s3       <= n_s2;
			side_s3    <= side_s2;

			if (big_s3 || (|acc_s3[65:48])) begin
				ms_s4  <= 32'hFFFF_FFFF;
				sat_s4 <= 1'b1;
			end else begin
				ms_s4  <= acc_s3[47:16];
				sat_s4 <= 1'b0;
			end
			n_s4       <= n_s3;
			side_s4    <= side_s3;
		end
	end

	assign out_valid = vld_s4;
	assign ms_new    = ms_s4;
	assign sat       = sat_s4;
	assign n         = n_s4;
	assign side_out  = side_s4;

endmodule

/* src/rpu_sqrt.sv */
module rpu_sqrt #(
	parameter int FRACTION_BITS = 24
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic                                  in_valid,
	input  logic [31:0]                           ms_new,
	input  rpu_pkg::rt_side_t                     side_in,
	output logic                                  out_valid,
	output logic [(33+FRACTION_BITS)/2-1:0]       root,
	output rpu_pkg::rt_side_t                     side_out
);

	localparam int VW = 32 + FRACTION_BITS;
	localparam int RW = (VW + 1) / 2;
	localparam int PW = 2 * RW;

	logic [PW-1:0]     v_in;
	logic [PW-1:0]     v_s    [RW];
	logic [RW+1:0]     rem_s  [RW];
	logic [RW-1:0]     root_s [RW];
	rpu_pkg::rt_side_t side_s [RW];
	logic              vld_s  [RW];

	assign v_in = PW'({ms_new, {FRACTION_BITS{1'b0}}});

	// One root bit per stage, two radicand bits consumed per stage.
	for (genvar i = 0; i < RW; i++) begin : g_st
		logic [PW-1:0]     v_p;
		logic [RW+1:0]     rem_p;
		logic [RW-1:0]     root_p;
		rpu_pkg::rt_side_t side_p;
		logic              vld_p;
		logic [RW+3:0]     rem_sh;
		logic [RW+3:0]     trial;

		if (i == 0) begin : g_first
			assign v_p    = v_in;
			assign rem_p  = '0;
			assign root_p = '0;
			assign side_p = side_in;
			assign vld_p  = in_valid;
		end else begin : g_next
			assign v_p    = v_s[i-1];
			assign rem_p  = rem_s[i-1];
			assign root_p = root_s[i-1];
			assign side_p = side_s[i-1];
			assign vld_p  = vld_s[i-1];
		end

		assign rem_sh = {rem_p, v_p[PW-1-2*i -: 2]};
		assign trial  = (RW+4)'({root_p, 2'b01});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				v_s[i]    <= v_p;
				side_s[i] <= side_p;
				if (rem_sh >= trial) begin
					rem_s[i]  <= (RW+2)'(rem_sh - trial);
					root_s[i] <= {root_p[RW-2:0], 1'b1};
				end else begin
					rem_s[i]  <= (RW+2)'(rem_sh);
					root_s[i] <= {root_p[RW-2:0], 1'b0};
				end
			end
		end
	end

	assign out_valid = vld_s[RW-1];
	assign root      = root_s[RW-1];
	assign side_out  = side_s[RW-1];

endmodule

/* src/rpu_div.sv */
module rpu_div #(
	parameter int FRACTION_BITS = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_valid,
	input  logic [(33+FRACTION_BITS)/2-1:0]   root,
	input  logic [15:0]                       eps,
	input  logic [55:0]                       n,
	input  rpu_pkg::rt_side_t                 side_in,
	output logic                              out_valid,
	output logic [31:0]                       q,
	output logic                              ovf,
	output rpu_pkg::dv_side_t                 side_out
);

	localparam int RW = (33 + FRACTION_BITS) / 2;
	localparam int DW = RW + 25;
	localparam int NW = 56 + FRACTION_BITS;
	localparam int QB = 32;

	// Setup stage: denominator, numerator split and overflow test.
	logic [RW:0]       den;
	logic [NW-1:0]     num;
	logic [DW-1:0]     d_full;
	logic [DW-1:0]     top;

	logic [DW-1:0]     d_s0;
	logic [DW-1:0]     rem_s0;
	logic [QB-1:0]     nlow_s0;
	logic              ovf_s0;
	rpu_pkg::dv_side_t side_s0;
	logic              vld_s0;

	logic [DW-1:0]     d_s     [QB];
	logic [DW-1:0]     rem_s   [QB];
	logic [QB-1:0]     nlow_s  [QB];
	logic [QB-1:0]     q_s     [QB];
	logic              ovf_s   [QB];
	rpu_pkg::dv_side_t side_s  [QB];
	logic              vld_s   [QB];

	always_comb begin
		den = (RW+1)'(root) + (RW+1)'(eps);
		if (den == '0) begin
			den = (RW+1)'(1);
		end
		num    = {n, {FRACTION_BITS{1'b0}}};
		d_full = {den, 24'd0};
		top    = DW'(num[NW-1:QB]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else if (en) begin
			vld_s0 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s0    <= d_full;
			ovf_s0  <= top >= d_full;
			rem_s0  <= top;
			nlow_s0 <= num[QB-1:0];
			side_s0 <= '{base: side_in.base, ms: side_in.ms, sat: side_in.sat};
		end
	end

	// Restoring division, one quotient bit per stage.
	for (genvar k = 0; k < QB; k++) begin : g_st
		logic [DW-1:0]     d_p;
		logic [DW-1:0]     rem_p;
		logic [QB-1:0]     nlow_p;
		logic [QB-1:0]     q_p;
		logic              ovf_p;
		rpu_pkg::dv_side_t side_p;
		logic              vld_p;
		logic [DW:0]       r2;

		if (k == 0) begin : g_first
			assign d_p    = d_s0;
			assign rem_p  = rem_s0;
			assign nlow_p = nlow_s0;
			assign q_p    = '0;
			assign ovf_p  = ovf_s0;
			assign side_p = side_s0;
			assign vld_p  = vld_s0;
		end else begin : g_next
			assign d_p    = d_s[k-1];
			assign rem_p  = rem_s[k-1];
			assign nlow_p = nlow_s[k-1];
			assign q_p    = q_s[k-1];
			assign ovf_p  = ovf_s[k-1];
			assign side_p = side_s[k-1];
			assign vld_p  = vld_s[k-1];
		end

		assign r2 = {rem_p, nlow_p[QB-1-k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				d_s[k]    <= d_p;
				nlow_s[k] <= nlow_p;
				ovf_s[k]  <= ovf_p;
				side_s[k] <= side_p;
				if (r2 >= {1'b0, d_p}) begin
					rem_s[k] <= DW'(r2 - {1'b0, d_p});
					q_s[k]   <= {q_p[QB-2:0], 1'b1};
				end else begin
					rem_s[k] <= DW'(r2);
					q_s[k]   <= {q_p[QB-2:0], 1'b0};
				end
			end
		end
	end

	assign out_valid = vld_s[QB-1];
	assign q         = q_s[QB-1];
	assign ovf       = ovf_s[QB-1];
	assign side_out  = side_s[QB-1];

endmodule

/* src/rmsprop_parameter_update_top.sv */
// RMSProp element update, fully pipelined.
// An element passes the input stage and the mean square, square root, divider,
// final and output register stages; the square root takes one stage per root bit
// and the divider one per quotient bit. Throughput: one element per cycle while the
// overflow entry is free; a two-entry output buffer keeps s_tready registered.
// Reset (arst_n low) empties the pipeline and loads the register defaults.
module rmsprop_parameter_update_top #(
	parameter int FRACTION_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port.
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data,
	// Input stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,   // param_in, mean_square_in, gradient
	input  logic        s_tuser,   // is_bias
	input  logic        s_tlast,   // last_element
	// Output stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // param_out, mean_square_out
	output logic        m_tuser,   // saturated
	output logic        m_tlast    // last
);

	localparam int RW = (33 + FRACTION_BITS) / 2;

	// Configuration registers.
	logic [15:0] decay_q;
	logic [23:0] wrate_q;
	logic [23:0] brate_q;
	logic [15:0] eps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decay_q <= rpu_pkg::DECAY_RST;
			wrate_q <= rpu_pkg::WRATE_RST;
			brate_q <= rpu_pkg::BRATE_RST;
			eps_q   <= rpu_pkg::EPS_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				rpu_pkg::REG_DECAY: decay_q <= cfg_data[15:0];
				rpu_pkg::REG_WRATE: wrate_q <= cfg_data;
				rpu_pkg::REG_BRATE: brate_q <= cfg_data;
				rpu_pkg::REG_EPS:   eps_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Pipeline advances whenever the overflow entry of the output buffer is free.
	logic skid_vld_q;
	logic en;
	logic accept;

	assign en       = !skid_vld_q;
	assign s_tready = !skid_vld_q;
	assign accept   = s_tvalid && s_tready;

	// Input stage: gradient magnitude and rate select.
	logic [31:0]    gmag_s1;
	logic [31:0]    ms_s1;
	logic [23:0]    rate_s1;
	rpu_pkg::side_t side_s1;
	logic           vld_s1;
	logic [31:0]    grad;

	assign grad = s_tdata[95:64];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			gmag_s1 <= grad[31] ? 32'(-grad) : grad;
			ms_s1   <= s_tdata[63:32];
			rate_s1 <= s_tuser ? brate_q : wrate_q;
			side_s1 <= '{w: s_tdata[31:0], gneg: grad[31], last: s_tlast};
		end
	end

	// Mean square update.
	logic           ms_vld;
	logic [31:0]    ms_new;
	logic           ms_sat;
	logic [55:0]    ms_n;
	rpu_pkg::side_t ms_side;

	rpu_ms #(.FRACTION_BITS(FRACTION_BITS)) u_ms (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s1),
		.gmag     (gmag_s1),
		.ms_in    (ms_s1),
		.rate     (rate_s1),
		.decay    (decay_q),
		.side_in  (side_s1),
		.out_valid(ms_vld),
		.ms_new   (ms_new),
		.sat      (ms_sat),
		.n        (ms_n),
		.side_out (ms_side)
	);

	// Square root of the new mean square.
	rpu_pkg::rt_side_t rt_side_in;
	rpu_pkg::rt_side_t rt_side;
	logic              rt_vld;
	logic [RW-1:0]     root;

	assign rt_side_in = '{base: ms_side, ms: ms_new, n: ms_n, sat: ms_sat};

	rpu_sqrt #(.FRACTION_BITS(FRACTION_BITS)) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (ms_vld),
		.ms_new   (ms_new),
		.side_in  (rt_side_in),
		.out_valid(rt_vld),
		.root     (root),
		.side_out (rt_side)
	);

	// Step size division.
	logic              dv_vld;
	logic [31:0]       dv_q;
	logic              dv_ovf;
	rpu_pkg::dv_side_t dv_side;

	rpu_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (rt_vld),
		.root     (root),
		.eps      (eps_q),
		.n        (rt_side.n),
		.side_in  (rt_side),
		.out_valid(dv_vld),
		.q        (dv_q),
		.ovf      (dv_ovf),
		.side_out (dv_side)
	);

	// Final stage: apply the step and clamp to the parameter range.
	logic signed [34:0] wext;
	logic signed [34:0] qc;
	logic signed [34:0] sum;
	rpu_pkg::res_t      res_c;
	rpu_pkg::res_t      res_s2;
	logic               vld_s2;

	always_comb begin
		wext = 35'(signed'(dv_side.base.w));
		qc   = dv_ovf ? 35'sh1_0000_0000 : signed'(35'(dv_q));
		sum  = dv_side.base.gneg ? wext - qc : wext + qc;
		res_c.ms   = dv_side.ms;
		res_c.last = dv_side.base.last;
		res_c.sat  = dv_side.sat;
		res_c.param = sum[31:0];
		if (sum > 35'sh0_7FFF_FFFF) begin
			res_c.param = 32'h7FFF_FFFF;
			res_c.sat   = 1'b1;
		end else if (sum < -35'sh0_8000_0000) begin
			res_c.param = 32'h8000_0000;
			res_c.sat   = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s2 <= res_c;
		end
	end

	// Output register plus one overflow entry.
	logic          out_vld_q;
	rpu_pkg::res_t out_q;
	rpu_pkg::res_t skid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (en && vld_s2) begin
			if (!out_vld_q || m_tready) begin
				out_vld_q <= 1'b1;
			end else begin
				skid_vld_q <= 1'b1;
			end
		end else if (out_vld_q && m_tready) begin
			if (skid_vld_q) begin
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && vld_s2) begin
			if (!out_vld_q || m_tready) begin
				out_q <= res_s2;
			end else begin
				skid_q <= res_s2;
			end
		end else if (out_vld_q && m_tready && skid_vld_q) begin
			out_q <= skid_q;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {out_q.ms, out_q.param};
	assign m_tuser  = out_q.sat;
	assign m_tlast  = out_q.last;

`ifndef ASSERT_OFF
	// A held overflow entry always sits behind a valid output.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("overflow entry full while output empty");

	// A transfer out of a full buffer frees the overflow entry.
	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_vld_q && m_tready) |=> !skid_vld_q)
		else $error("overflow entry not drained");

	// The saturation flag only comes with a value at a rail.
	a_sat_rail: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[63:32] == 32'hFFFF_FFFF ||
			m_tdata[31:0] == 32'h7FFF_FFFF || m_tdata[31:0] == 32'h8000_0000))
		else $error("saturation flag without clamped value");
`endif

endmodule
